// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle assertion failed.");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle assertion failed.");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/snv_pkg.sv =====
`default_nettype none

package snv_pkg;

   // Length limits of the two parts of an 8.3 name.
   localparam logic [3:0] BASE_MAX = 4'd8;
   localparam logic [2:0] EXT_MAX  = 3'd3;

   // Character codes with a special role.
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_DOT = 8'h2E;

   // True for uppercase letters, digits and the permitted punctuation marks.
   function automatic logic allowed_char(input logic [7:0] c);
      logic result;
      result = 1'b0;
      if (c inside {[8'h41:8'h5A]}) begin
         result = 1'b1;
      end else if (c inside {[8'h30:8'h39]}) begin
         result = 1'b1;
      end else if (c inside {8'h5F, 8'h24, 8'h7E, 8'h21, 8'h23, 8'h25, 8'h2D,
                             8'h7B, 8'h7D, 8'h28, 8'h29, 8'h40, 8'h5E, 8'h26}) begin
         // _ $ ~ ! # % - { } ( ) @ ^ &
         result = 1'b1;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/short_name_validator_core.sv =====
`default_nettype none

// Channel    Dir  Payload                                   Moves when
// req_*      in   tdata[7:0] name_byte                      tvalid & tready
// rsp_*      out  tdata[0] is_valid, tdata[7:1] zero        tvalid & tready
//
// One name byte is taken every cycle unless the input is held; a byte waits in the
// input register and is checked against the name state when it leaves it.
// A zero byte reaches the result register through the input register.
// Reset is synchronous and clears the name state and both valid flags.
// Only a terminator waiting on a full, stalled result register holds the input.
module short_name_validator_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] name_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] is_valid, [7:1] zero
);
   import snv_pkg::*;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Name state.
   logic       dot_seen_ff, dot_seen_in;
   logic [3:0] base_count_ff, base_count_in;
   logic [2:0] ext_count_ff, ext_count_in;
   logic       fault_seen_ff, fault_seen_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_valid_ff;

   logic       advance;
   logic       term;

   // A byte moves on unless it is a terminator facing a full, stalled result.
   assign term       = (in_byte_ff == CHAR_NUL);
   assign advance    = in_valid_ff && (!term || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   // Name state update for the byte in the input register.
   always_comb begin
      dot_seen_in   = dot_seen_ff;
      base_count_in = base_count_ff;
      ext_count_in  = ext_count_ff;
      fault_seen_in = fault_seen_ff;
      if (advance) begin
         if (term) begin
            dot_seen_in   = 1'b0;
            base_count_in = '0;
            ext_count_in  = '0;
            fault_seen_in = 1'b0;
         end else if (!fault_seen_ff) begin
            if (in_byte_ff == CHAR_DOT) begin
               if (dot_seen_ff || (base_count_ff == '0)) begin
                  fault_seen_in = 1'b1;
               end else begin
                  dot_seen_in = 1'b1;
               end
            end else if (!allowed_char(in_byte_ff)) begin
               fault_seen_in = 1'b1;
            end else if (!dot_seen_ff) begin
               if (base_count_ff >= BASE_MAX) begin
                  fault_seen_in = 1'b1;
               end else begin
                  base_count_in = base_count_ff + 4'd1;
               end
            end else begin
               if (ext_count_ff >= EXT_MAX) begin
                  fault_seen_in = 1'b1;
               end else begin
                  ext_count_in = ext_count_ff + 3'd1;
               end
            end
         end
      end
   end

   // Result valid: set by a terminator, cleared when the transaction completes.
   always_comb begin
      if (advance && term) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         dot_seen_ff   <= 1'b0;
         base_count_ff <= '0;
         ext_count_ff  <= '0;
         fault_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         dot_seen_ff   <= dot_seen_in;
         base_count_ff <= base_count_in;
         ext_count_ff  <= ext_count_in;
         fault_seen_ff <= fault_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && term) begin
         is_valid_ff <= !fault_seen_ff && (base_count_ff != '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, is_valid_ff};

   // Checks on the name state and the result path.
`include "assert_macros.svh"
   `ASSERT_SAME_CYCLE(base_in_range, clock, reset, 1'b1, base_count_ff <= BASE_MAX)
   `ASSERT_SAME_CYCLE(ext_in_range, clock, reset, 1'b1, ext_count_ff <= EXT_MAX)
   `ASSERT_SAME_CYCLE(ext_needs_dot, clock, reset, ext_count_ff != '0, dot_seen_ff)
   `ASSERT_NEXT_CYCLE(term_clears, clock, reset, advance && term,
      rsp_valid_ff && !dot_seen_ff && (base_count_ff == '0) && !fault_seen_ff)

endmodule

`default_nettype wire

// ===== tb/short_name_checker.sv =====
// Watches both channels of the short-name validator, predicts the verdict for every
// terminated name and compares it with each result transaction in order.
module short_name_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] name_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // [0] is_valid, [7:1] zero
   output int         failures,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import snv_pkg::*;

   // Running state of the name that is being scanned.
   logic       in_extension;
   logic [3:0] stem_chars;
   logic [2:0] ext_len;
   logic       rejected;

   // Verdicts of finished names, oldest first.
   logic       verdict_queue[$];
   logic       wanted_verdict;

   // Uppercase letters, digits and the fourteen punctuation marks pass.
   function automatic logic is_legal_char(input logic [7:0] c);
      if (c >= "A" && c <= "Z") begin
         return 1'b1;
      end
      if (c >= "0" && c <= "9") begin
         return 1'b1;
      end
      case (c)
         "_", "$", "~", "!", "#", "%", "-", "{", "}", "(", ")", "@", "^", "&": begin
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   task automatic clear_name();
      in_extension = 1'b0;
      stem_chars   = '0;
      ext_len      = '0;
      rejected     = 1'b0;
   endtask

   // Advance the name state by one byte; a terminator queues the verdict.
   task automatic scan_byte(input logic [7:0] c);
      if (c == CHAR_NUL) begin
         verdict_queue.push_back(!rejected && stem_chars != 4'd0);
         clear_name();
      end else if (!rejected) begin
         if (c == CHAR_DOT) begin
            if (in_extension || stem_chars == 4'd0) begin
               rejected = 1'b1;
            end else begin
               in_extension = 1'b1;
            end
         end else if (!is_legal_char(c)) begin
            rejected = 1'b1;
         end else if (!in_extension) begin
            if (stem_chars >= BASE_MAX) begin
               rejected = 1'b1;
            end else begin
               stem_chars = stem_chars + 4'd1;
            end
         end else if (ext_len >= EXT_MAX) begin
            rejected = 1'b1;
         end else begin
            ext_len = ext_len + 3'd1;
         end
      end
   endtask

   // Results are checked before the byte of the same cycle is scanned.
   always @(posedge clock) begin
      if (reset) begin
         clear_name();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t ns: result transaction 0x%02h arrived with no name pending",
                        $time, rsp_tdata);
               failures++;
            end else begin
               wanted_verdict = verdict_queue.pop_front();
               if (rsp_tdata[0] !== wanted_verdict) begin
                  $display("%0t ns: is_valid mismatch, expected %b, actual %b",
                           $time, wanted_verdict, rsp_tdata[0]);
                  failures++;
               end
               if (rsp_tdata[7:1] !== 7'd0) begin
                  $display("%0t ns: padding bits mismatch, expected 0x00, actual 0x%02h",
                           $time, rsp_tdata[7:1]);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata);
         end
      end
      pending = verdict_queue.size();
   end

endmodule

// ===== tb/tb.sv =====
// Drives names into the short-name validator one byte per transaction and gives
// the verdict from the failure count of the checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import snv_pkg::*;

   localparam int BYTE_TARGET    = 1100;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   int         failures;
   int         pending_results;
   int         bytes_sent;
   int         names_sent;
   int         quiet_cycles;
   logic       idle_on = 1'b1;
   logic       long_hold = 1'b0;
   string      name_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_$~!#%-{}()@^&";

   short_name_validator_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   short_name_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #6 clock = ~clock;
      end
   end

   // Result side: random back-pressure while idling is on, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         rsp_tready <= idle_on ? ($urandom_range(99) >= 23) : 1'b1;
      end
   end

   // Ends the run when no transaction moves on either channel for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("short_name_validator_core verification failed");
      $finish;
   end

   // Offers one byte, starting and ending at a falling edge.
   task automatic send_byte(input logic [7:0] b);
      while (idle_on && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do begin
         @(posedge clock);
      end while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
      send_byte(CHAR_NUL);
      names_sent++;
   endtask

   // Mostly well-formed names of random content, some broken, some pure noise.
   task automatic send_random_name();
      logic [7:0] text[$];
      int         base_n;
      int         ext_n;
      int         pick;
      int         spot;
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(14)) text.push_back(8'($urandom_range(255, 1)));
      end else begin
         base_n = (pick < 15) ? 0 : (pick < 25) ? $urandom_range(12, 9) : $urandom_range(8, 1);
         ext_n  = ($urandom_range(9) == 0) ? $urandom_range(5, 4) : $urandom_range(3);
         repeat (base_n) text.push_back(name_chars[$urandom_range(name_chars.len() - 1)]);
         if ($urandom_range(99) < 70) begin
            text.push_back(CHAR_DOT);
            repeat (ext_n) text.push_back(name_chars[$urandom_range(name_chars.len() - 1)]);
         end
         // Break about a quarter of the names at one random position.
         if (text.size() > 0 && $urandom_range(99) < 25) begin
            spot = $urandom_range(text.size() - 1);
            case ($urandom_range(2))
               0: text[spot] = 8'($urandom_range(255, 1));
               1: text[spot] = 8'($urandom_range("z", "a"));
               default: text.insert(spot, CHAR_DOT);
            endcase
         end
      end
      foreach (text[i]) begin
         send_byte(text[i]);
      end
      send_byte(CHAR_NUL);
      names_sent++;
   endtask

   initial begin
      bytes_sent = 0;
      names_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed names: empty, leading dot, trailing dot, full length,
      // lowercase, a high byte and a second dot.
      send_text("");
      send_text(".");
      send_text("A.");
      send_text("ABCDEFGH.~&_");
      send_text("z");
      send_byte(8'hFF);
      send_byte(CHAR_NUL);
      names_sent++;
      send_text("A..");

      // Random names, with a long result hold-off, a full drain and a
      // stretch without idling on either side.
      while (bytes_sent < BYTE_TARGET) begin
         if (names_sent == 40) begin
            long_hold = 1'b1;
         end
         if (names_sent == 90) begin
            req_tvalid <= 1'b0;
            while (pending_results != 0) @(negedge clock);
         end
         idle_on = !(names_sent >= 120 && names_sent < 200);
         send_random_name();
      end
      req_tvalid <= 1'b0;

      // Drain the outstanding results, then allow for the pipeline latency.
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && pending_results == 0) begin
         $display("short_name_validator_core verification clean");
      end else begin
         $display("short_name_validator_core verification failed");
      end
      $finish;
   end

endmodule
